// ===== rtl/dtr_pkg.sv =====
// Shared types, codes and defaults for the table-driven automaton runner.
`default_nettype none
package dtr_pkg;

	// Default sizing
	localparam int DEF_NUM_STATES  = 64;
	localparam int DEF_NUM_EVENTS  = 32;
	localparam int DEF_TRANS_LIMIT = 1024;

	// Field widths fixed by the interface
	localparam int STATE_W  = 6;
	localparam int EVENT_W  = 5;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MARK    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STEP    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DEAD   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NONE   = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 2'd2;

	// Configuration register file contents
	typedef struct packed {
		logic [6:0]         state_count;
		logic [5:0]         event_count;
		logic [STATE_W-1:0] start_state;
	} cfg_t;

	// One transition table entry
	typedef struct packed {
		logic               valid;
		logic [STATE_W-1:0] dest;
	} entry_t;

	// Control sequencer states
	typedef enum logic [1:0] {
		FSM_SWEEP,
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

endpackage
`default_nettype wire

// ===== rtl/dtr_table_mem.sv =====
// Transition table storage: one write port, one read port, registered read data.
`default_nettype none
module dtr_table_mem #(
	parameter int DEPTH = dtr_pkg::DEF_NUM_STATES * dtr_pkg::DEF_NUM_EVENTS,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire dtr_pkg::entry_t wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr,
	output dtr_pkg::entry_t      rdata
);

	dtr_pkg::entry_t mem_q [DEPTH];
	dtr_pkg::entry_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered output
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/dtr_ctrl.sv =====
// Command sequencer: table read/modify/write, marks, trace state and response register.
`default_nettype none
module dtr_ctrl #(
	parameter int NUM_STATES  = dtr_pkg::DEF_NUM_STATES,
	parameter int NUM_EVENTS  = dtr_pkg::DEF_NUM_EVENTS,
	parameter int TRANS_LIMIT = dtr_pkg::DEF_TRANS_LIMIT,
	localparam int DEPTH = NUM_STATES * NUM_EVENTS,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire dtr_pkg::cfg_t                   cfg,
	// command channel
	input  wire logic                            cmd_valid,
	output logic                                 cmd_ready,
	input  wire logic [dtr_pkg::CMD_W-1:0]       command,
	input  wire logic [dtr_pkg::STATE_W-1:0]     state_index,
	input  wire logic [dtr_pkg::EVENT_W-1:0]     event_index,
	input  wire logic [dtr_pkg::STATE_W-1:0]     dest_state,
	// response channel
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output logic [dtr_pkg::STATUS_W-1:0]         status,
	output logic [dtr_pkg::STATE_W-1:0]          state_out,
	output logic                                 is_marked,
	output logic                                 trace_alive,
	// table memory
	output logic                                 mem_we,
	output logic [AW-1:0]                        mem_waddr,
	output dtr_pkg::entry_t                      mem_wdata,
	output logic                                 mem_re,
	output logic [AW-1:0]                        mem_raddr,
	input  wire dtr_pkg::entry_t                 mem_rdata
);

	localparam int SW = $clog2(NUM_STATES);
	localparam int TW = $clog2(TRANS_LIMIT + 1);
	localparam logic [AW-1:0] SWEEP_LAST = AW'(DEPTH - 1);
	localparam logic [TW-1:0] LIMIT      = TW'(TRANS_LIMIT);

	// State index in range of both the register and the storage
	function automatic logic state_ok(input logic [dtr_pkg::STATE_W-1:0] s,
			input logic [6:0] cnt);
		return (7'(s) < cnt) && (32'(s) < NUM_STATES);
	endfunction

	function automatic logic event_ok(input logic [dtr_pkg::EVENT_W-1:0] e,
			input logic [5:0] cnt);
		return (6'(e) < cnt) && (32'(e) < NUM_EVENTS);
	endfunction

	// Table slot of (state, event)
	function automatic logic [AW-1:0] slot(input logic [dtr_pkg::STATE_W-1:0] s,
			input logic [dtr_pkg::EVENT_W-1:0] e);
		return AW'(32'(s) * NUM_EVENTS + 32'(e));
	endfunction

	function automatic logic [SW-1:0] sidx(input logic [dtr_pkg::STATE_W-1:0] s);
		return SW'(s);
	endfunction

	dtr_pkg::fsm_t fsm_q, fsm_d;

	logic [dtr_pkg::STATE_W-1:0]  cur_q;
	logic                         alive_q;
	logic [TW-1:0]                total_q;
	logic [NUM_STATES-1:0]        marks_q;
	logic [AW-1:0]                sweep_q;

	logic [dtr_pkg::CMD_W-1:0]    cmd_q;
	logic [dtr_pkg::STATE_W-1:0]  src_q;
	logic [dtr_pkg::EVENT_W-1:0]  ev_q;
	logic [dtr_pkg::STATE_W-1:0]  dst_q;

	logic                         rsp_valid_q;
	logic [dtr_pkg::STATUS_W-1:0] status_q;
	logic [dtr_pkg::STATE_W-1:0]  shown_q;
	logic                         marked_q;
	logic                         alive_out_q;

	logic accept;
	logic out_free;
	logic commit;
	logic sweep_done;

	// Execute-stage results
	logic [dtr_pkg::STATUS_W-1:0] status_c;
	logic [dtr_pkg::STATE_W-1:0]  cur_c;
	logic [dtr_pkg::STATE_W-1:0]  shown_c;
	logic                         alive_c;
	logic                         marked_c;
	logic                         add_ok;
	logic                         mark_ok;
	logic                         do_clear;

	assign accept     = cmd_valid && cmd_ready;
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign commit     = (fsm_q == dtr_pkg::FSM_EXEC) && out_free;
	assign sweep_done = (sweep_q == SWEEP_LAST);

	// Execute: decide the command against the entry read when it was accepted
	always_comb begin
		logic src_ok;
		logic ev_ok;
		logic dst_ok;
		logic cur_ok;
		logic start_ok;
		logic hit;
		logic miss;
		src_ok   = state_ok(src_q, cfg.state_count);
		ev_ok    = event_ok(ev_q, cfg.event_count);
		dst_ok   = state_ok(dst_q, cfg.state_count);
		cur_ok   = state_ok(cur_q, cfg.state_count);
		start_ok = state_ok(cfg.start_state, cfg.state_count);
		hit      = mem_rdata.valid;
		miss     = 1'b0;
		status_c = dtr_pkg::STAT_OK;
		cur_c    = cur_q;
		alive_c  = alive_q;
		add_ok   = 1'b0;
		mark_ok  = 1'b0;
		do_clear = 1'b0;
		shown_c  = '0;
		case (cmd_q)
			dtr_pkg::CMD_CLEAR: begin
				do_clear = 1'b1;
				cur_c    = cfg.start_state;
				alive_c  = start_ok;
			end
			dtr_pkg::CMD_ADD: begin
				if (src_ok && ev_ok && dst_ok && !hit && (total_q < LIMIT)) begin
					add_ok = 1'b1;
				end else begin
					status_c = dtr_pkg::STAT_REJECT;
				end
			end
			dtr_pkg::CMD_MARK: begin
				if (src_ok) begin
					mark_ok = 1'b1;
				end else begin
					status_c = dtr_pkg::STAT_REJECT;
				end
			end
			dtr_pkg::CMD_RESTART: begin
				cur_c    = cfg.start_state;
				alive_c  = start_ok;
				status_c = start_ok ? dtr_pkg::STAT_OK : dtr_pkg::STAT_DEAD;
			end
			dtr_pkg::CMD_STEP: begin
				if (alive_q && ev_ok && cur_ok && hit) begin
					cur_c = mem_rdata.dest;
				end else begin
					alive_c  = 1'b0;
					status_c = dtr_pkg::STAT_DEAD;
				end
			end
			dtr_pkg::CMD_LOOKUP: begin
				if (!(src_ok && ev_ok && hit)) begin
					miss     = 1'b1;
					status_c = dtr_pkg::STAT_DEAD;
				end
			end
			default: begin
				status_c = dtr_pkg::STAT_REJECT;
			end
		endcase
		// Reported state: looked-up destination or the updated current state
		if (cmd_q == dtr_pkg::CMD_LOOKUP) begin
			shown_c = miss ? '0 : mem_rdata.dest;
		end else begin
			shown_c = cur_c;
		end
		// Mark bit of the reported state, including a mark made by this command
		if (miss || do_clear) begin
			marked_c = 1'b0;
		end else begin
			marked_c = state_ok(shown_c, cfg.state_count) &&
				(marks_q[sidx(shown_c)] || (mark_ok && (src_q == shown_c)));
		end
	end

	// Next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			dtr_pkg::FSM_SWEEP: begin
				if (sweep_done) begin
					fsm_d = dtr_pkg::FSM_IDLE;
				end
			end
			dtr_pkg::FSM_IDLE: begin
				if (cmd_valid) begin
					fsm_d = dtr_pkg::FSM_EXEC;
				end
			end
			dtr_pkg::FSM_EXEC: begin
				if (out_free) begin
					fsm_d = do_clear ? dtr_pkg::FSM_SWEEP : dtr_pkg::FSM_IDLE;
				end
			end
			default: begin
				fsm_d = dtr_pkg::FSM_SWEEP;
			end
		endcase
	end

	// Outputs: handshake and memory port control
	always_comb begin
		cmd_ready = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = slot(state_index, event_index);
		mem_we    = 1'b0;
		mem_waddr = slot(src_q, ev_q);
		mem_wdata = '{valid: 1'b1, dest: dst_q};
		case (fsm_q)
			dtr_pkg::FSM_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = '0;
			end
			dtr_pkg::FSM_IDLE: begin
				cmd_ready = 1'b1;
				mem_re    = cmd_valid;
				if (command == dtr_pkg::CMD_STEP) begin
					mem_raddr = slot(cur_q, event_index);
				end
			end
			dtr_pkg::FSM_EXEC: begin
				mem_we = commit && add_ok;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// Sequencer state and clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= dtr_pkg::FSM_SWEEP;
			sweep_q <= '0;
		end else begin
			fsm_q <= fsm_d;
			if (fsm_q == dtr_pkg::FSM_SWEEP) begin
				sweep_q <= sweep_done ? '0 : sweep_q + AW'(1);
			end
		end
	end

	// Automaton state: current state, trace flag, count, marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			alive_q <= 1'b1;
			total_q <= '0;
			marks_q <= '0;
		end else if (commit) begin
			cur_q   <= cur_c;
			alive_q <= alive_c;
			if (do_clear) begin
				total_q <= '0;
				marks_q <= '0;
			end else begin
				if (add_ok) begin
					total_q <= total_q + TW'(1);
				end
				if (mark_ok) begin
					marks_q[sidx(src_q)] <= 1'b1;
				end
			end
		end
	end

	// Command holding register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			src_q <= state_index;
			ev_q  <= event_index;
			dst_q <= dest_state;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q    <= status_c;
			shown_q     <= shown_c;
			marked_q    <= marked_c;
			alive_out_q <= alive_c;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign state_out   = shown_q;
	assign is_marked   = marked_q;
	assign trace_alive = alive_out_q;

endmodule
`default_nettype wire

// ===== rtl/dfa_transition_table_runner.sv =====
// Top level of the table-driven automaton runner: config registers, sequencer, table.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  cmd     | in        | cmd_valid/cmd_ready  | command, state_index, event_index,
//          |           |                      | dest_state
//  rsp     | out       | rsp_valid/rsp_ready  | status, state_out, is_marked, trace_alive
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// Each command passes through IDLE and EXEC: the transfer in IDLE issues the table read,
// EXEC uses the registered read data and writes back; the next transfer follows.
// A clear adds a sweep that invalidates every one of the NUM_STATES*NUM_EVENTS entries.
// After reset the same sweep runs with cmd_ready low; config writes are taken meanwhile.
// A result waiting in the response register stalls only the command behind it.
`default_nettype none
module dfa_transition_table_runner #(
	parameter int NUM_STATES  = dtr_pkg::DEF_NUM_STATES,
	parameter int NUM_EVENTS  = dtr_pkg::DEF_NUM_EVENTS,
	parameter int TRANS_LIMIT = dtr_pkg::DEF_TRANS_LIMIT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [dtr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dtr_pkg::CFG_W-1:0]         cfg_data,
	// commands
	input  wire logic                              cmd_valid,
	output logic                                   cmd_ready,
	input  wire logic [dtr_pkg::CMD_W-1:0]         command,
	input  wire logic [dtr_pkg::STATE_W-1:0]       state_index,
	input  wire logic [dtr_pkg::EVENT_W-1:0]       event_index,
	input  wire logic [dtr_pkg::STATE_W-1:0]       dest_state,
	// results
	output logic                                   rsp_valid,
	input  wire logic                              rsp_ready,
	output logic [dtr_pkg::STATUS_W-1:0]           status,
	output logic [dtr_pkg::STATE_W-1:0]            state_out,
	output logic                                   is_marked,
	output logic                                   trace_alive
);

	localparam int DEPTH = NUM_STATES * NUM_EVENTS;
	localparam int AW    = $clog2(DEPTH);

	dtr_pkg::cfg_t   cfg_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	dtr_pkg::entry_t mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	dtr_pkg::entry_t mem_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.state_count <= 7'd1;
			cfg_q.event_count <= '0;
			cfg_q.start_state <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dtr_pkg::REG_STATE_COUNT: cfg_q.state_count <= cfg_data;
				dtr_pkg::REG_EVENT_COUNT: cfg_q.event_count <= cfg_data[5:0];
				dtr_pkg::REG_START_STATE: cfg_q.start_state <= cfg_data[5:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	dtr_ctrl #(
		.NUM_STATES  (NUM_STATES),
		.NUM_EVENTS  (NUM_EVENTS),
		.TRANS_LIMIT (TRANS_LIMIT)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.state_index (state_index),
		.event_index (event_index),
		.dest_state  (dest_state),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.state_out   (state_out),
		.is_marked   (is_marked),
		.trace_alive (trace_alive),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	dtr_table_mem #(
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire

// ===== rtl/dtr_checker.sv =====
// Port-level checks for the automaton runner, bound to the top level.
`default_nettype none
module dtr_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              cfg_we,
	input wire logic [dtr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input wire logic [dtr_pkg::CFG_W-1:0]         cfg_data,
	input wire logic                              cmd_valid,
	input wire logic                              cmd_ready,
	input wire logic [dtr_pkg::CMD_W-1:0]         command,
	input wire logic [dtr_pkg::STATE_W-1:0]       state_index,
	input wire logic [dtr_pkg::EVENT_W-1:0]       event_index,
	input wire logic [dtr_pkg::STATE_W-1:0]       dest_state,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_ready,
	input wire logic [dtr_pkg::STATUS_W-1:0]      status,
	input wire logic [dtr_pkg::STATE_W-1:0]       state_out,
	input wire logic                              is_marked,
	input wire logic                              trace_alive
);

	// A stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
			$stable(state_out) && $stable(is_marked) && $stable(trace_alive))
		else $error("result changed while stalled");

	// One command at a time: no transfer on the edge right after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while previous one executes");

	// Status code three is never produced
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status != dtr_pkg::STAT_NONE)
		else $error("illegal status code");

	// A new result only follows an accepted command that has passed through EXEC
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid ##1 rsp_valid |-> !$past(cmd_valid && cmd_ready))
		else $error("result appeared too early");

endmodule

bind dfa_transition_table_runner dtr_checker u_dtr_checker (.*);
`default_nettype wire

// ===== bench/dfa_transition_table_runner_test.sv =====
// Self-checking testbench for the table-driven automaton runner: directed script, random traffic.
`default_nettype none
module dfa_transition_table_runner_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dtr_pkg::*;

	localparam int NSTATES      = DEF_NUM_STATES;
	localparam int NEVENTS      = DEF_NUM_EVENTS;
	localparam int LIMIT_TOTAL  = DEF_TRANS_LIMIT;
	localparam int SLOTS        = NSTATES * NEVENTS;
	// a clear keeps sweeping the table after its result has gone out
	localparam int SETTLE       = SLOTS + 16;
	localparam int STALL_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_PCT     = 29;

	// command codes the block leaves unused
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]   op;
		logic [STATE_W-1:0] src;
		logic [EVENT_W-1:0] ev;
		logic [STATE_W-1:0] dst;
	} command_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [STATE_W-1:0]  state;
		logic                marked;
		logic                alive;
	} answer_t;

	// one line of the directed script: a register write or a command
	typedef struct packed {
		logic                 is_write;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		command_t             cmd;
		logic                 pinned;
		answer_t              want;
	} script_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	logic [CMD_W-1:0] command = '0;
	logic [STATE_W-1:0] state_index = '0;
	logic [EVENT_W-1:0] event_index = '0;
	logic [STATE_W-1:0] dest_state = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [STATE_W-1:0] state_out;
	logic is_marked;
	logic trace_alive;

	dfa_transition_table_runner dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.command(command), .state_index(state_index),
		.event_index(event_index), .dest_state(dest_state),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.status(status), .state_out(state_out),
		.is_marked(is_marked), .trace_alive(trace_alive)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Automaton mirror: table, marks, trace and register shadows
	// ---------------------------------------------------------------
	bit entry_valid [SLOTS];
	logic [STATE_W-1:0] entry_dest [SLOTS];
	bit state_marked [NSTATES];
	logic [STATE_W-1:0] cur_state;
	bit trace_ok;
	int defined_total;
	logic [6:0] shadow_states = 7'd1;
	logic [5:0] shadow_events = 6'd0;
	logic [STATE_W-1:0] shadow_start = '0;

	answer_t awaited_answers [$];
	int mismatch_count = 0;
	bit steady = 1'b0;
	int holds_asked = 0;
	int holds_done = 0;
	bit sent_since_drain = 1'b0;
	script_row_t script [$];

	function automatic int states_used();
		return (shadow_states > NSTATES) ? NSTATES : int'(shadow_states);
	endfunction

	function automatic int events_used();
		return (shadow_events > NEVENTS) ? NEVENTS : int'(shadow_events);
	endfunction

	function automatic bit state_in(int s);
		return s < states_used();
	endfunction

	function automatic bit event_in(int e);
		return e < events_used();
	endfunction

	function automatic void restart_trace();
		cur_state = shadow_start;
		trace_ok = state_in(int'(shadow_start));
	endfunction

	function automatic void wipe_automaton();
		for (int i = 0; i < SLOTS; i++) begin
			entry_valid[i] = 1'b0;
			entry_dest[i] = '0;
		end
		for (int i = 0; i < NSTATES; i++)
			state_marked[i] = 1'b0;
		defined_total = 0;
		restart_trace();
	endfunction

	// Apply one command to the mirror and return the answer it gives
	function automatic answer_t automaton_answer(command_t c);
		answer_t a;
		int slot;
		logic [STATE_W-1:0] shown;
		bit show_cur;
		a.status = STAT_OK;
		show_cur = 1'b1;
		shown = '0;
		case (c.op)
			CMD_CLEAR: wipe_automaton();
			CMD_ADD: begin
				if (!state_in(c.src) || !event_in(c.ev) || !state_in(c.dst)) begin
					a.status = STAT_REJECT;
				end else begin
					slot = int'(c.src) * NEVENTS + int'(c.ev);
					if (entry_valid[slot] || defined_total >= LIMIT_TOTAL) begin
						a.status = STAT_REJECT;
					end else begin
						entry_valid[slot] = 1'b1;
						entry_dest[slot] = c.dst;
						defined_total++;
					end
				end
			end
			CMD_MARK: begin
				if (!state_in(c.src))
					a.status = STAT_REJECT;
				else
					state_marked[c.src] = 1'b1;
			end
			CMD_RESTART: begin
				restart_trace();
				a.status = trace_ok ? STAT_OK : STAT_DEAD;
			end
			CMD_STEP: begin
				slot = int'(cur_state) * NEVENTS + int'(c.ev);
				if (trace_ok && event_in(c.ev) && state_in(cur_state) && entry_valid[slot]) begin
					cur_state = entry_dest[slot];
				end else begin
					trace_ok = 1'b0;
					a.status = STAT_DEAD;
				end
			end
			CMD_LOOKUP: begin
				show_cur = 1'b0;
				slot = int'(c.src) * NEVENTS + int'(c.ev);
				if (state_in(c.src) && event_in(c.ev) && entry_valid[slot])
					shown = entry_dest[slot];
				else
					a.status = STAT_DEAD;
			end
			default: a.status = STAT_REJECT;
		endcase
		if (show_cur)
			shown = cur_state;
		a.state = shown;
		if (c.op == CMD_LOOKUP && a.status != STAT_OK)
			a.marked = 1'b0;
		else
			a.marked = state_in(shown) && state_marked[shown];
		a.alive = trace_ok;
		return a;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [STATE_W-1:0] pick_state();
		int top;
		top = (states_used() < NSTATES) ? states_used() : NSTATES - 1;
		if ($urandom_range(0, 9) == 0)
			return STATE_W'($urandom);
		return STATE_W'($urandom_range(0, top));
	endfunction

	function automatic logic [EVENT_W-1:0] pick_event();
		int top;
		top = (events_used() < NEVENTS) ? events_used() : NEVENTS - 1;
		if ($urandom_range(0, 9) == 0)
			return EVENT_W'($urandom);
		return EVENT_W'($urandom_range(0, top));
	endfunction

	// Mostly in-range traffic that builds and walks the table, some noise
	function automatic command_t random_command(bit no_clear);
		command_t c;
		int roll;
		roll = $urandom_range(0, 99);
		c.src = pick_state();
		c.ev = pick_event();
		c.dst = pick_state();
		if (roll < 1)
			c.op = no_clear ? CMD_RESTART : CMD_CLEAR;
		else if (roll < 30)
			c.op = CMD_ADD;
		else if (roll < 40)
			c.op = CMD_MARK;
		else if (roll < 52)
			c.op = CMD_RESTART;
		else if (roll < 82)
			c.op = CMD_STEP;
		else if (roll < 95)
			c.op = CMD_LOOKUP;
		else
			c.op = ($urandom_range(0, 1) == 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
		return c;
	endfunction

	// Offer one command; called at a falling edge, returns at a falling edge
	task automatic send_command(command_t c, bit pinned, answer_t want);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c.op;
		state_index <= c.src;
		event_index <= c.ev;
		dest_state <= c.dst;
		do
			@(posedge clk);
		while (!cmd_ready);
		want = pinned ? want : automaton_answer(c);
		if (pinned)
			void'(automaton_answer(c));
		awaited_answers.push_back(want);
		sent_since_drain = 1'b1;
		@(negedge clk);
	endtask

	// Let every answer come back and any table sweep run out
	task automatic quiesce();
		cmd_valid <= 1'b0;
		if (sent_since_drain) begin
			while (awaited_answers.size() != 0)
				@(negedge clk);
			repeat (SETTLE) @(negedge clk);
			sent_since_drain = 1'b0;
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_STATE_COUNT: shadow_states = val;
			REG_EVENT_COUNT: shadow_events = val[5:0];
			REG_START_STATE: shadow_start = val[STATE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_mode(int sc, int ec, int st);
		quiesce();
		write_reg(REG_STATE_COUNT, CFG_W'(sc));
		write_reg(REG_EVENT_COUNT, CFG_W'(ec));
		write_reg(REG_START_STATE, CFG_W'(st));
	endtask

	task automatic random_phase(int count, bit no_clear);
		command_t c;
		for (int k = 0; k < count; k++) begin
			c = random_command(no_clear);
			send_command(c, 1'b0, '0);
		end
	endtask

	function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		script_row_t r;
		r = '0;
		r.is_write = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		script.push_back(r);
	endfunction

	function automatic void add_check(logic [CMD_W-1:0] op, int src, int ev, int dst,
			logic [STATUS_W-1:0] st, int so, bit mk, bit al);
		script_row_t r;
		r = '0;
		r.cmd = '{op, STATE_W'(src), EVENT_W'(ev), STATE_W'(dst)};
		r.pinned = 1'b1;
		r.want = '{st, STATE_W'(so), mk, al};
		script.push_back(r);
	endfunction

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		$display("%0t ns: %s got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	initial begin
		answer_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				if (awaited_answers.size() == 0) begin
					report_mismatch("result with nothing pending, state_out", state_out, 0);
				end else begin
					want = awaited_answers.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (state_out !== want.state)
						report_mismatch("state_out", state_out, want.state);
					if (is_marked !== want.marked)
						report_mismatch("is_marked", is_marked, want.marked);
					if (trace_alive !== want.alive)
						report_mismatch("trace_alive", trace_alive, want.alive);
				end
			end
		end
	end

	// Result side: random back-pressure unless steady, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (holds_done < holds_asked) begin
				holds_done++;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	initial begin
		int quiet_run;
		quiet_run = 0;
		while (quiet_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
				quiet_run = 0;
			else
				quiet_run++;
		end
		$display("dfa_transition_table_runner: mismatch");
		$finish;
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		command_t c;
		int fill_slot;
		wipe_automaton();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed script; reset values: one state, no events, start at zero
		add_check(CMD_STEP,     0,  0,  0, STAT_DEAD,   0, 0, 0);
		add_check(CMD_LOOKUP,   0, 31,  0, STAT_DEAD,   0, 0, 0);
		add_check(CMD_ADD,     63, 31, 63, STAT_REJECT, 0, 0, 0);
		add_check(CMD_RESTART,  0,  0,  0, STAT_OK,     0, 0, 1);
		add_check(CMD_SPARE_LO, 0,  0,  0, STAT_REJECT, 0, 0, 1);
		add_check(CMD_MARK,     0,  0,  0, STAT_OK,     0, 1, 1);
		add_check(CMD_SPARE_HI, 0,  0,  0, STAT_REJECT, 0, 1, 1);
		add_check(CMD_MARK,    63,  0,  0, STAT_REJECT, 0, 1, 1);
		// counts above the sizes saturate; start at the top state
		add_write(REG_STATE_COUNT, 7'd127);
		add_write(REG_EVENT_COUNT, 7'd63);
		add_write(REG_START_STATE, 7'd63);
		add_check(CMD_ADD,     63, 31,  0, STAT_OK,      0, 1, 1);
		add_check(CMD_ADD,     63, 31,  5, STAT_REJECT,  0, 1, 1);
		add_check(CMD_ADD,      0,  0, 63, STAT_OK,      0, 1, 1);
		add_check(CMD_RESTART,  0,  0,  0, STAT_OK,     63, 0, 1);
		add_check(CMD_STEP,     0, 31,  0, STAT_OK,      0, 1, 1);
		add_check(CMD_STEP,     0,  0,  0, STAT_OK,     63, 0, 1);
		add_check(CMD_STEP,     0,  1,  0, STAT_DEAD,   63, 0, 0);
		add_check(CMD_STEP,     0, 31,  0, STAT_DEAD,   63, 0, 0);
		add_check(CMD_LOOKUP,  63, 31,  0, STAT_OK,      0, 1, 0);
		add_check(CMD_LOOKUP,   5,  5,  0, STAT_DEAD,    0, 0, 0);
		add_check(CMD_MARK,    63,  0,  0, STAT_OK,     63, 1, 0);
		// no states in use: start state out of range, entries hidden
		add_write(REG_STATE_COUNT, 7'd0);
		add_write(REG_EVENT_COUNT, 7'd32);
		add_write(REG_START_STATE, 7'd0);
		add_check(CMD_RESTART,  0,  0,  0, STAT_DEAD,    0, 0, 0);
		add_check(CMD_MARK,     0,  0,  0, STAT_REJECT,  0, 0, 0);
		add_check(CMD_LOOKUP,   0,  0,  0, STAT_DEAD,    0, 0, 0);
		add_check(CMD_CLEAR,    0,  0,  0, STAT_OK,      0, 0, 0);
		add_write(REG_STATE_COUNT, 7'd64);
		add_check(CMD_RESTART,  0,  0,  0, STAT_OK,      0, 0, 1);
		add_check(CMD_LOOKUP,   0,  0,  0, STAT_DEAD,    0, 0, 1);
		add_check(CMD_ADD,      0,  0,  0, STAT_OK,      0, 0, 1);

		@(negedge clk);
		foreach (script[i]) begin
			if (script[i].is_write) begin
				quiesce();
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else begin
				send_command(script[i].cmd, script[i].pinned, script[i].want);
			end
		end

		// small dense tables where traces live long
		set_mode(4, 2, 0);
		random_phase(200, 1'b0);
		set_mode(8, 4, 7);
		random_phase(200, 1'b0);
		set_mode(1, 1, 0);
		steady = 1'b1;
		random_phase(100, 1'b0);

		// full size: fill the table up to the transition limit and past it
		set_mode(64, 32, $urandom_range(0, 63));
		c = '{CMD_CLEAR, STATE_W'(0), EVENT_W'(0), STATE_W'(0)};
		send_command(c, 1'b0, '0);
		fill_slot = 0;
		for (int k = 0; k < 1300; k++) begin
			if (k == 300)
				steady = 1'b0;
			if (k == 400)
				holds_asked++;
			if (k % 5 == 4) begin
				c = random_command(1'b1);
			end else begin
				c.op = CMD_ADD;
				c.src = STATE_W'(fill_slot / NEVENTS);
				c.ev = EVENT_W'(fill_slot % NEVENTS);
				c.dst = STATE_W'($urandom_range(0, NSTATES - 1));
				fill_slot++;
			end
			send_command(c, 1'b0, '0);
		end

		// saturated counts, then no events with the start state out of range
		set_mode(100, 40, 63);
		random_phase(100, 1'b0);
		set_mode(3, 0, 5);
		random_phase(60, 1'b0);

		quiesce();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("dfa_transition_table_runner: match");
		else
			$display("dfa_transition_table_runner: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/dtr_pkg.sv
rtl/dtr_table_mem.sv
rtl/dtr_ctrl.sv
rtl/dfa_transition_table_runner.sv
rtl/dtr_checker.sv
bench/dfa_transition_table_runner_test.sv
